// ----- design/vmbm_pkg.sv -----
// Package for the video mode best-match selector: field widths, register
// indexes, attribute and memory model codes, and the shared structs.
// No dependencies.
package vmbm_pkg;

  localparam int RES_BITS_DEF = 16;

  localparam int ID_W    = 16;
  localparam int ATTR_W  = 16;
  localparam int MODEL_W = 8;
  localparam int RES_W   = 16;
  localparam int DEPTH_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_PREF_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREF_DEPTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_DEPTH  = 3'd5;

  localparam logic [RES_W-1:0]   PREF_WIDTH_RST   = 16'd1024;
  localparam logic [RES_W-1:0]   PREF_HEIGHT_RST  = 16'd768;
  localparam logic [DEPTH_W-1:0] PREF_DEPTH_RST   = 8'd32;
  localparam logic [RES_W-1:0]   LEAST_WIDTH_RST  = 16'd640;
  localparam logic [RES_W-1:0]   LEAST_HEIGHT_RST = 16'd480;
  localparam logic [DEPTH_W-1:0] LEAST_DEPTH_RST  = 8'd8;

  // Available, color, graphics and linear frame buffer bits.
  localparam logic [ATTR_W-1:0] ATTR_REQUIRED = 16'h0099;

  localparam logic [MODEL_W-1:0] MODEL_PACKED = 8'd4;
  localparam logic [MODEL_W-1:0] MODEL_DIRECT = 8'd6;

  typedef struct packed {
    logic [RES_W-1:0]   pref_width;
    logic [RES_W-1:0]   pref_height;
    logic [DEPTH_W-1:0] pref_depth;
    logic [RES_W-1:0]   least_width;
    logic [RES_W-1:0]   least_height;
    logic [DEPTH_W-1:0] least_depth;
  } cfg_t;

  // Screened candidate handed from the screening stage to the selector.
  typedef struct packed {
    logic [ID_W-1:0] mode_id;
    logic            last;
    logic            elig;
    logic            exact;
    logic            smaller;
  } cand_t;

endpackage

// ----- design/vmbm_if.sv -----
// Valid/ready channel interfaces for mode descriptors and selection results.
// Depends on vmbm_pkg for the field widths.
interface vmbm_in_if;
  import vmbm_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    mode_id;
  logic               info_ok;
  logic [ATTR_W-1:0]  mode_attributes;
  logic [MODEL_W-1:0] memory_model;
  logic [RES_W-1:0]   x_res;
  logic [RES_W-1:0]   y_res;
  logic [DEPTH_W-1:0] bits_per_pixel;
  logic               last_mode;

  modport source (output valid, mode_id, info_ok, mode_attributes, memory_model,
                  x_res, y_res, bits_per_pixel, last_mode, input ready);
  modport sink (input valid, mode_id, info_ok, mode_attributes, memory_model,
                x_res, y_res, bits_per_pixel, last_mode, output ready);
endinterface

interface vmbm_out_if;
  import vmbm_pkg::*;

  logic            valid;
  logic            ready;
  logic            status;
  logic [ID_W-1:0] chosen_mode_id;

  modport source (output valid, status, chosen_mode_id, input ready);
  modport sink (input valid, status, chosen_mode_id, output ready);
endinterface

// ----- design/vmbm_cfg_regs.sv -----
// Configuration registers of the mode selector and the registered preferred
// pixel count. Depends on vmbm_pkg.
module vmbm_cfg_regs #(
  parameter int RES_BITS = vmbm_pkg::RES_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [vmbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vmbm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output vmbm_pkg::cfg_t                      cfg,
  output logic [2*RES_BITS-1:0]               pref_pix
);
  import vmbm_pkg::*;

  localparam int PIX_W = 2 * RES_BITS;

  cfg_t             cfg_r;
  logic [PIX_W-1:0] pref_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pref_width   <= PREF_WIDTH_RST;
      cfg_r.pref_height  <= PREF_HEIGHT_RST;
      cfg_r.pref_depth   <= PREF_DEPTH_RST;
      cfg_r.least_width  <= LEAST_WIDTH_RST;
      cfg_r.least_height <= LEAST_HEIGHT_RST;
      cfg_r.least_depth  <= LEAST_DEPTH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PREF_WIDTH:   cfg_r.pref_width   <= cfg_wdata[RES_W-1:0];
        CFG_PREF_HEIGHT:  cfg_r.pref_height  <= cfg_wdata[RES_W-1:0];
        CFG_PREF_DEPTH:   cfg_r.pref_depth   <= cfg_wdata[DEPTH_W-1:0];
        CFG_LEAST_WIDTH:  cfg_r.least_width  <= cfg_wdata[RES_W-1:0];
        CFG_LEAST_HEIGHT: cfg_r.least_height <= cfg_wdata[RES_W-1:0];
        CFG_LEAST_DEPTH:  cfg_r.least_depth  <= cfg_wdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // Recomputed every cycle; the user changes configuration only while the block is idle, unenforced.
  always_ff @(posedge clk) begin
    pref_pix_r <= PIX_W'(cfg_r.pref_width[RES_BITS-1:0]) *
                  PIX_W'(cfg_r.pref_height[RES_BITS-1:0]);
  end

  assign cfg      = cfg_r;
  assign pref_pix = pref_pix_r;

endmodule

// ----- design/vmbm_screen.sv -----
// Input register and screening stage: eligibility, exact match, size flags
// and the mode's pixel product. Depends on vmbm_pkg and vmbm_in_if.
module vmbm_screen #(
  parameter int RES_BITS = vmbm_pkg::RES_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  vmbm_in_if.sink               in_bus,
  input  vmbm_pkg::cfg_t        cfg,
  output logic                  cand_valid,
  output vmbm_pkg::cand_t       cand_info,
  output logic [2*RES_BITS-1:0] cand_pix,
  input  logic                  cand_ready
);
  import vmbm_pkg::*;

  localparam int PIX_W = 2 * RES_BITS;

  logic                s0_valid_r;
  logic [ID_W-1:0]     s0_id_r;
  logic                s0_ok_r;
  logic [ATTR_W-1:0]   s0_attr_r;
  logic [MODEL_W-1:0]  s0_model_r;
  logic [RES_BITS-1:0] s0_xr_r;
  logic [RES_BITS-1:0] s0_yr_r;
  logic [DEPTH_W-1:0]  s0_bpp_r;
  logic                s0_last_r;

  logic                cand_valid_r;
  cand_t               cand_info_r;
  logic [PIX_W-1:0]    cand_pix_r;

  logic                s1_take;
  logic                in_take;
  cand_t               cand_nxt;
  logic [RES_BITS-1:0] pw;
  logic [RES_BITS-1:0] ph;

  assign s1_take      = !cand_valid_r || cand_ready;
  assign in_bus.ready = !s0_valid_r || s1_take;
  assign in_take      = in_bus.valid && in_bus.ready;

  assign pw = cfg.pref_width[RES_BITS-1:0];
  assign ph = cfg.pref_height[RES_BITS-1:0];

  always_comb begin
    cand_nxt.mode_id = s0_id_r;
    cand_nxt.last    = s0_last_r;
    cand_nxt.elig    = s0_ok_r &&
                       ((s0_attr_r & ATTR_REQUIRED) == ATTR_REQUIRED) &&
                       (s0_model_r == MODEL_PACKED || s0_model_r == MODEL_DIRECT) &&
                       (s0_xr_r >= cfg.least_width[RES_BITS-1:0]) &&
                       (s0_yr_r >= cfg.least_height[RES_BITS-1:0]) &&
                       (s0_bpp_r >= cfg.least_depth);
    cand_nxt.exact   = (s0_xr_r == pw) && (s0_yr_r == ph) &&
                       (s0_bpp_r == cfg.pref_depth);
    cand_nxt.smaller = (s0_xr_r < pw) || (s0_yr_r < ph);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r   <= 1'b0;
      cand_valid_r <= 1'b0;
    end else begin
      if (in_bus.ready) begin
        s0_valid_r <= in_bus.valid;
      end
      if (s1_take) begin
        cand_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s0_id_r    <= in_bus.mode_id;
      s0_ok_r    <= in_bus.info_ok;
      s0_attr_r  <= in_bus.mode_attributes;
      s0_model_r <= in_bus.memory_model;
      s0_xr_r    <= in_bus.x_res[RES_BITS-1:0];
      s0_yr_r    <= in_bus.y_res[RES_BITS-1:0];
      s0_bpp_r   <= in_bus.bits_per_pixel;
      s0_last_r  <= in_bus.last_mode;
    end
    if (s1_take && s0_valid_r) begin
      cand_info_r <= cand_nxt;
      cand_pix_r  <= PIX_W'(s0_xr_r) * PIX_W'(s0_yr_r);
    end
  end

  assign cand_valid = cand_valid_r;
  assign cand_info  = cand_info_r;
  assign cand_pix   = cand_pix_r;

endmodule

// ----- design/vmbm_select.sv -----
// Scoring, running best-mode state and the result register of the mode
// selector. Depends on vmbm_pkg and vmbm_out_if.
module vmbm_select #(
  parameter int RES_BITS = vmbm_pkg::RES_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cand_valid,
  input  vmbm_pkg::cand_t       cand_info,
  input  logic [2*RES_BITS-1:0] cand_pix,
  input  logic [2*RES_BITS-1:0] pref_pix,
  output logic                  cand_ready,
  vmbm_out_if.source            out_bus
);
  import vmbm_pkg::*;

  localparam int PIX_W   = 2 * RES_BITS;
  localparam int SCORE_W = PIX_W + 1;

  logic [ID_W-1:0]    best_mode_r,    best_mode_nxt;
  logic [SCORE_W-1:0] best_score_r,   best_score_nxt;
  logic               have_best_r,    have_best_nxt;
  logic               exact_locked_r, exact_locked_nxt;
  logic               out_valid_r,    out_valid_nxt;
  logic               out_status_r,   out_status_nxt;
  logic [ID_W-1:0]    out_id_r,       out_id_nxt;

  logic               fire;
  logic [PIX_W-1:0]   diff;
  logic [SCORE_W-1:0] score;

  // Only a last beat needs the result register, so other beats never stall.
  assign cand_ready = !(cand_info.last && out_valid_r && !out_bus.ready);
  assign fire       = cand_valid && cand_ready;

  assign diff  = (cand_pix > pref_pix) ? (cand_pix - pref_pix) : (pref_pix - cand_pix);
  assign score = cand_info.smaller ? {diff, 1'b0} : {1'b0, diff};

  always_comb begin
    best_mode_nxt    = best_mode_r;
    best_score_nxt   = best_score_r;
    have_best_nxt    = have_best_r;
    exact_locked_nxt = exact_locked_r;
    out_valid_nxt    = out_valid_r && !out_bus.ready;
    out_status_nxt   = out_status_r;
    out_id_nxt       = out_id_r;

    if (fire) begin
      if (!exact_locked_r && cand_info.elig) begin
        if (cand_info.exact) begin
          best_mode_nxt    = cand_info.mode_id;
          have_best_nxt    = 1'b1;
          exact_locked_nxt = 1'b1;
        end else if (score <= best_score_r) begin
          best_mode_nxt  = cand_info.mode_id;
          best_score_nxt = score;
          have_best_nxt  = 1'b1;
        end
      end
      if (cand_info.last) begin
        out_valid_nxt    = 1'b1;
        out_status_nxt   = !have_best_nxt;
        out_id_nxt       = have_best_nxt ? best_mode_nxt : '0;
        // The list is closed; start the next one from a clean state.
        best_mode_nxt    = '0;
        best_score_nxt   = '1;
        have_best_nxt    = 1'b0;
        exact_locked_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_mode_r    <= '0;
      best_score_r   <= '1;
      have_best_r    <= 1'b0;
      exact_locked_r <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      best_mode_r    <= best_mode_nxt;
      best_score_r   <= best_score_nxt;
      have_best_r    <= have_best_nxt;
      exact_locked_r <= exact_locked_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.chosen_mode_id = out_id_r;

endmodule

// ----- design/video_mode_best_match.sv -----
// Video mode best-match selector, top level.
// A last input beat passes the input, candidate and result registers before its result is valid.
// Throughput: one descriptor per cycle; the input stalls only while a last
// beat waits on a full result register that is not being taken.
// Reset (synchronous, rst_n low): selection state cleared, registers take their
// default values, both channels empty.
module video_mode_best_match #(
  parameter int RES_BITS = vmbm_pkg::RES_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  vmbm_in_if.sink                         in_bus,
  vmbm_out_if.source                      out_bus,
  input  logic                            cfg_we,
  input  logic [vmbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vmbm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import vmbm_pkg::*;

  localparam int PIX_W = 2 * RES_BITS;

  cfg_t             cfg;
  logic [PIX_W-1:0] pref_pix;
  logic             cand_valid;
  cand_t            cand_info;
  logic [PIX_W-1:0] cand_pix;
  logic             cand_ready;

  vmbm_cfg_regs #(.RES_BITS(RES_BITS)) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .pref_pix  (pref_pix)
  );

  vmbm_screen #(.RES_BITS(RES_BITS)) u_screen (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .cfg        (cfg),
    .cand_valid (cand_valid),
    .cand_info  (cand_info),
    .cand_pix   (cand_pix),
    .cand_ready (cand_ready)
  );

  vmbm_select #(.RES_BITS(RES_BITS)) u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .cand_valid (cand_valid),
    .cand_info  (cand_info),
    .cand_pix   (cand_pix),
    .pref_pix   (pref_pix),
    .cand_ready (cand_ready),
    .out_bus    (out_bus)
  );

  // A last candidate that moves on always lands in the result register.
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    cand_valid && cand_ready && cand_info.last |=> out_bus.valid)
    else $error("last candidate did not produce a result beat");

  // The input is held back only by a result that waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> out_bus.valid && !out_bus.ready)
    else $error("input stalled without a blocked result");

  // A "no mode" result carries a zero mode id.
  a_none_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.status |-> out_bus.chosen_mode_id == '0)
    else $error("no-mode result with nonzero mode id");

endmodule

// ----- tb/video_mode_best_match_checker.sv -----
`timescale 1ns / 1ps
// Checker for the video mode best-match selector: watches the descriptor,
// result and register ports, predicts each selection and compares it.
// Depends on vmbm_pkg and the channel interfaces in vmbm_if.sv.
module video_mode_best_match_checker #(
  parameter int RES_BITS = vmbm_pkg::RES_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  vmbm_in_if                              in_bus,
  vmbm_out_if                             out_bus,
  input  logic                            cfg_we,
  input  logic [vmbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vmbm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              mismatches,
  output int                              picks_pending,
  output int                              picks_checked
);
  import vmbm_pkg::*;

  typedef struct packed {
    logic            status;
    logic [ID_W-1:0] mode_id;
  } pick_t;

  localparam logic [32:0] SCORE_NONE = '1;

  cfg_t            regs;
  logic [ID_W-1:0] best_id;
  logic [32:0]     best_score;
  logic            have_best;
  logic            locked;
  pick_t           pick_q[$];

  initial begin
    mismatches    = 0;
    picks_pending = 0;
    picks_checked = 0;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void restart_list();
    best_id    = '0;
    best_score = SCORE_NONE;
    have_best  = 1'b0;
    locked     = 1'b0;
  endfunction

  // Screens one descriptor and folds it into the running best choice.
  function automatic void weigh_mode(input logic [ID_W-1:0] id,
                                     input logic ok,
                                     input logic [ATTR_W-1:0] attr,
                                     input logic [MODEL_W-1:0] model,
                                     input logic [RES_W-1:0] x_in,
                                     input logic [RES_W-1:0] y_in,
                                     input logic [DEPTH_W-1:0] bpp);
    logic [RES_BITS-1:0] xr, yr, pw, ph, mw, mh;
    logic [32:0]         pix, pref_pix, score;
    xr = x_in[RES_BITS-1:0];
    yr = y_in[RES_BITS-1:0];
    pw = regs.pref_width[RES_BITS-1:0];
    ph = regs.pref_height[RES_BITS-1:0];
    mw = regs.least_width[RES_BITS-1:0];
    mh = regs.least_height[RES_BITS-1:0];
    if (!ok || (attr & ATTR_REQUIRED) != ATTR_REQUIRED) return;
    if (model != MODEL_PACKED && model != MODEL_DIRECT) return;
    if (xr < mw || yr < mh || bpp < regs.least_depth) return;
    if (xr == pw && yr == ph && bpp == regs.pref_depth) begin
      best_id   = id;
      have_best = 1'b1;
      locked    = 1'b1;
      return;
    end
    pix      = 33'(xr) * 33'(yr);
    pref_pix = 33'(pw) * 33'(ph);
    score    = (pix > pref_pix) ? pix - pref_pix : pref_pix - pix;
    // A mode short of the preferred size in either direction is penalized.
    if (xr < pw || yr < ph) score = score << 1;
    if (score <= best_score) begin
      best_id    = id;
      best_score = score;
      have_best  = 1'b1;
    end
  endfunction

  always @(posedge clk) begin : watch
    pick_t got, want;
    if (!rst_n) begin
      regs = '{pref_width: PREF_WIDTH_RST, pref_height: PREF_HEIGHT_RST,
               pref_depth: PREF_DEPTH_RST, least_width: LEAST_WIDTH_RST,
               least_height: LEAST_HEIGHT_RST, least_depth: LEAST_DEPTH_RST};
      restart_list();
      pick_q.delete();
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.status  = out_bus.status;
        got.mode_id = out_bus.chosen_mode_id;
        if (pick_q.size() == 0) begin
          report_mismatch($sformatf("result beat status %0d id %h with nothing pending",
                                    got.status, got.mode_id));
        end else begin
          want = pick_q.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status expected %0d got %0d",
                                      want.status, got.status));
          if (got.mode_id !== want.mode_id)
            report_mismatch($sformatf("chosen_mode_id expected %h got %h",
                                      want.mode_id, got.mode_id));
          picks_checked++;
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        if (!locked)
          weigh_mode(in_bus.mode_id, in_bus.info_ok, in_bus.mode_attributes,
                     in_bus.memory_model, in_bus.x_res, in_bus.y_res,
                     in_bus.bits_per_pixel);
        if (in_bus.last_mode) begin
          if (have_best) begin
            want.status  = 1'b0;
            want.mode_id = best_id;
          end else begin
            want.status  = 1'b1;
            want.mode_id = '0;
          end
          pick_q.push_back(want);
          restart_list();
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_PREF_WIDTH:   regs.pref_width   = cfg_wdata;
          CFG_PREF_HEIGHT:  regs.pref_height  = cfg_wdata;
          CFG_PREF_DEPTH:   regs.pref_depth   = cfg_wdata[DEPTH_W-1:0];
          CFG_LEAST_WIDTH:  regs.least_width  = cfg_wdata;
          CFG_LEAST_HEIGHT: regs.least_height = cfg_wdata;
          CFG_LEAST_DEPTH:  regs.least_depth  = cfg_wdata[DEPTH_W-1:0];
          default: ;
        endcase
      end
    end
    picks_pending = pick_q.size();
  end

endmodule

// ----- tb/video_mode_best_match_tb.sv -----
`timescale 1ns / 1ps
// Top of the video mode best-match testbench: clock, reset, mode lists,
// register settings and the verdict. Depends on vmbm_pkg, vmbm_if.sv, the
// selector RTL and video_mode_best_match_checker.
module video_mode_best_match_tb;
  import vmbm_pkg::*;

  localparam int RES_BITS        = RES_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int NUM_PHASES      = 8;
  localparam int CYCLE_LIMIT     = 100000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic [ATTR_W-1:0]  ATTR_AVAILABLE  = 16'h0001;
  localparam logic [MODEL_W-1:0] MODEL_NONCHAIN4 = 8'd5;

  typedef struct packed {
    logic [ID_W-1:0]    mode_id;
    logic               info_ok;
    logic [ATTR_W-1:0]  mode_attributes;
    logic [MODEL_W-1:0] memory_model;
    logic [RES_W-1:0]   x_res;
    logic [RES_W-1:0]   y_res;
    logic [DEPTH_W-1:0] bits_per_pixel;
    logic               last_mode;
  } mode_desc_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int   mismatches, picks_pending, picks_checked;
  int   modes_sent, settings_used, cycle_count, stall_left;
  bit   quiet;
  cfg_t settings;

  vmbm_in_if  in_bus();
  vmbm_out_if out_bus();

  video_mode_best_match #(.RES_BITS(RES_BITS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  video_mode_best_match_checker #(.RES_BITS(RES_BITS)) pick_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_bus        (in_bus),
    .out_bus       (out_bus),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .picks_pending (picks_pending),
    .picks_checked (picks_checked)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles, %0d selections outstanding",
               cycle_count, picks_pending);
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side back-pressure: random stall bursts.
  always @(negedge clk) begin
    if (!quiet && stall_left > 0) begin
      stall_left--;
      out_bus.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  task automatic send_mode(input mode_desc_t m);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_bus.valid           <= 1'b1;
    in_bus.mode_id         <= m.mode_id;
    in_bus.info_ok         <= m.info_ok;
    in_bus.mode_attributes <= m.mode_attributes;
    in_bus.memory_model    <= m.memory_model;
    in_bus.x_res           <= m.x_res;
    in_bus.y_res           <= m.y_res;
    in_bus.bits_per_pixel  <= m.bits_per_pixel;
    in_bus.last_mode       <= m.last_mode;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    modes_sent++;
  endtask

  // Ends a run of beats and lets the last selection come out of the pipeline.
  task automatic drain_lists();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (picks_pending == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(CFG_PREF_WIDTH, s.pref_width);
    write_reg(CFG_PREF_HEIGHT, s.pref_height);
    // Depth registers are 8 bits; the upper data bits carry noise.
    write_reg(CFG_PREF_DEPTH, {8'($urandom), s.pref_depth});
    write_reg(CFG_LEAST_WIDTH, s.least_width);
    write_reg(CFG_LEAST_HEIGHT, s.least_height);
    write_reg(CFG_LEAST_DEPTH, {8'($urandom), s.least_depth});
    write_reg(CFG_SPARE_LO, 16'($urandom));
    write_reg(CFG_SPARE_HI, 16'($urandom));
    settings = s;
    settings_used++;
  endtask

  function automatic mode_desc_t desc(input logic [ID_W-1:0] id, input logic ok,
                                      input logic [ATTR_W-1:0] attr,
                                      input logic [MODEL_W-1:0] model,
                                      input logic [RES_W-1:0] x, input logic [RES_W-1:0] y,
                                      input logic [DEPTH_W-1:0] bpp, input logic last);
    return '{mode_id: id, info_ok: ok, mode_attributes: attr, memory_model: model,
             x_res: x, y_res: y, bits_per_pixel: bpp, last_mode: last};
  endfunction

  function automatic logic [RES_W-1:0] pick_res(input logic [RES_W-1:0] pref,
                                                input logic [RES_W-1:0] lowest);
    int v;
    case ($urandom_range(0, 5))
      0:       v = pref;
      1, 2:    v = int'(pref) + int'($urandom_range(0, 128)) - 64;
      3:       v = $urandom_range(lowest, 16'hFFFF);
      4:       v = lowest;
      default: v = 16'hFFFF;
    endcase
    if (v < 0) v = 0;
    if (v > 16'hFFFF) v = 16'hFFFF;
    return v[RES_W-1:0];
  endfunction

  function automatic logic [DEPTH_W-1:0] pick_depth(input logic [DEPTH_W-1:0] pref,
                                                    input logic [DEPTH_W-1:0] lowest);
    case ($urandom_range(0, 3))
      0:       return pref;
      1:       return lowest;
      2:       return 8'hFF;
      default: return 8'($urandom_range(lowest, 8'hFF));
    endcase
  endfunction

  // An eligible-looking mode sized around the current preference.
  function automatic mode_desc_t good_mode();
    mode_desc_t m;
    m.mode_id         = 16'($urandom);
    m.info_ok         = 1'b1;
    m.mode_attributes = 16'($urandom) | ATTR_REQUIRED;
    m.memory_model    = $urandom_range(0, 1) ? MODEL_PACKED : MODEL_DIRECT;
    m.last_mode       = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      m.x_res          = settings.pref_width;
      m.y_res          = settings.pref_height;
      m.bits_per_pixel = settings.pref_depth;
    end else begin
      m.x_res          = pick_res(settings.pref_width, settings.least_width);
      m.y_res          = pick_res(settings.pref_height, settings.least_height);
      m.bits_per_pixel = pick_depth(settings.pref_depth, settings.least_depth);
    end
    return m;
  endfunction

  // Either pure noise or a good mode with one reason to reject it.
  function automatic mode_desc_t noisy_mode();
    mode_desc_t m;
    m = good_mode();
    case ($urandom_range(0, 5))
      0: begin
        m = mode_desc_t'({$urandom, $urandom, $urandom});
        m.last_mode = 1'b0;
      end
      1: m.info_ok = 1'b0;
      2: m.mode_attributes = m.mode_attributes ^ (ATTR_REQUIRED & 16'($urandom_range(1, 255)));
      3: m.memory_model = 8'($urandom);
      4: if (settings.least_width != 0)
        m.x_res = RES_W'($urandom_range(0, settings.least_width - 1));
      default: begin
        if (settings.least_height != 0)
          m.y_res = RES_W'($urandom_range(0, settings.least_height - 1));
        if (settings.least_depth != 0)
          m.bits_per_pixel = DEPTH_W'($urandom_range(0, settings.least_depth - 1));
      end
    endcase
    return m;
  endfunction

  function automatic cfg_t random_settings(input bit anything_goes);
    cfg_t s;
    if (anything_goes) begin
      s = cfg_t'({$urandom, $urandom, $urandom});
    end else begin
      s.pref_width  = RES_W'($urandom_range(256, 4096));
      s.pref_height = RES_W'($urandom_range(200, 2400));
      case ($urandom_range(0, 3))
        0:       s.pref_depth = 8'd16;
        1:       s.pref_depth = 8'd24;
        2:       s.pref_depth = 8'd15;
        default: s.pref_depth = 8'd32;
      endcase
      s.least_width  = RES_W'($urandom_range(0, s.pref_width));
      s.least_height = RES_W'($urandom_range(0, s.pref_height));
      s.least_depth  = DEPTH_W'($urandom_range(0, s.pref_depth));
    end
    return s;
  endfunction

  initial begin
    cfg_t       reset_values;
    mode_desc_t m, prev;
    int         sent_in_phase, list_len;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= '0;
    cfg_wdata        <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.mode_id   <= '0;
    in_bus.info_ok   <= 1'b0;
    in_bus.mode_attributes <= '0;
    in_bus.memory_model    <= '0;
    in_bus.x_res           <= '0;
    in_bus.y_res           <= '0;
    in_bus.bits_per_pixel  <= '0;
    in_bus.last_mode       <= 1'b0;
    quiet         = 1'b0;
    stall_left    = 0;
    modes_sent    = 0;
    settings_used = 1;
    cycle_count   = 0;
    reset_values = '{pref_width: PREF_WIDTH_RST, pref_height: PREF_HEIGHT_RST,
                     pref_depth: PREF_DEPTH_RST, least_width: LEAST_WIDTH_RST,
                     least_height: LEAST_HEIGHT_RST, least_depth: LEAST_DEPTH_RST};
    settings = reset_values;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed lists under the reset preference of 1024x768x32.
    // An unreadable descriptor that would otherwise be an exact match.
    send_mode(desc(16'h0001, 1'b0, ATTR_REQUIRED, MODEL_PACKED,
                   16'd1024, 16'd768, 8'd32, 1'b1));
    // One rejection cause per mode: nothing acceptable is left.
    send_mode(desc(16'h0002, 1'b1, ATTR_REQUIRED & ~ATTR_AVAILABLE, MODEL_DIRECT,
                   16'd1024, 16'd768, 8'd32, 1'b0));
    send_mode(desc(16'h0003, 1'b1, ATTR_REQUIRED, MODEL_NONCHAIN4,
                   16'd1024, 16'd768, 8'd32, 1'b0));
    send_mode(desc(16'h0004, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd639, 16'd768, 8'd32, 1'b0));
    send_mode(desc(16'h0005, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd1024, 16'd479, 8'd32, 1'b0));
    send_mode(desc(16'h0006, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd1024, 16'd768, 8'd7, 1'b1));
    // Smaller modes are penalized; an equal later score takes over.
    send_mode(desc(16'h0010, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd800, 16'd600, 8'd16, 1'b0));
    send_mode(desc(16'h0011, 1'b1, ATTR_REQUIRED, MODEL_DIRECT,
                   16'd1280, 16'd720, 8'd32, 1'b0));
    send_mode(desc(16'h0012, 1'b1, ATTR_REQUIRED, MODEL_DIRECT,
                   16'd1280, 16'd1024, 8'd32, 1'b0));
    send_mode(desc(16'h0013, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd1280, 16'd720, 8'd16, 1'b1));
    // An exact match locks the choice, even for the all-ones id.
    send_mode(desc(16'hFFFF, 1'b1, 16'hFFFF, MODEL_DIRECT,
                   16'd1024, 16'd768, 8'd32, 1'b0));
    send_mode(desc(16'h0020, 1'b1, ATTR_REQUIRED, MODEL_DIRECT,
                   16'd1024, 16'd768, 8'd32, 1'b0));
    send_mode(desc(16'h0021, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd1280, 16'd960, 8'd32, 1'b1));
    // An exact match with id zero on the last beat of its list.
    send_mode(desc(16'h1234, 1'b1, ATTR_REQUIRED, MODEL_PACKED,
                   16'd640, 16'd480, 8'd8, 1'b0));
    send_mode(desc(16'h0000, 1'b1, ATTR_REQUIRED, MODEL_DIRECT,
                   16'd1024, 16'd768, 8'd32, 1'b1));
    // Largest fields in a list of one, then a descriptor with zero attributes, sizes and depth.
    send_mode(desc(16'h8000, 1'b1, 16'hFFFF, MODEL_DIRECT,
                   16'hFFFF, 16'hFFFF, 8'hFF, 1'b1));
    send_mode(desc(16'h7FFF, 1'b1, 16'h0000, 8'hFF, 16'd0, 16'd0, 8'd0, 1'b1));
    drain_lists();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: ;
        1: load_settings('0);
        2: load_settings('1);
        3: load_settings(random_settings(1'b1));
        NUM_PHASES - 1: load_settings(reset_values);
        default: load_settings(random_settings(1'b0));
      endcase
      // The final phase runs with no idle cycles on either side.
      quiet = (phase == NUM_PHASES - 1);
      sent_in_phase = 0;
      while (sent_in_phase < ITEMS_PER_PHASE) begin
        list_len = $urandom_range(1, 10);
        for (int k = 0; k < list_len; k++) begin
          m = ($urandom_range(0, 4) == 0) ? noisy_mode() : good_mode();
          if (k > 0 && $urandom_range(0, 5) == 0) begin
            m.x_res          = prev.x_res;
            m.y_res          = prev.y_res;
            m.bits_per_pixel = prev.bits_per_pixel;
          end
          m.last_mode = (k == list_len - 1);
          send_mode(m);
          prev = m;
          sent_in_phase++;
        end
      end
      drain_lists();
    end

    $display("Checked %0d selections from %0d mode beats under %0d register settings,",
             picks_checked, modes_sent, settings_used);
    $display("with exact locks, ties, each rejection cause and bursts of idle and stall.");
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
